// ----- rtl/core/assert_macros.svh -----
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is held
`define STS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion, also checked during reset
`define STS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/sts_pkg.sv -----
// shared types, constants and lookup functions of the sql token scanner
`timescale 1ns / 1ps

package sts_pkg;

    // defaults
    localparam int ValueMaxDefault = 63;
    localparam int QueueDepth      = 4;
    localparam int QueuePtrW       = $clog2(QueueDepth);

    // record kinds
    localparam logic [1:0] RkValue   = 2'd0;
    localparam logic [1:0] RkToken   = 2'd1;
    localparam logic [1:0] RkBadChar = 2'd2;
    localparam logic [1:0] RkOpenStr = 2'd3;

    // token kinds
    localparam logic [4:0] TkEof     = 5'd0;
    localparam logic [4:0] TkIdent   = 5'd9;
    localparam logic [4:0] TkInt     = 5'd10;
    localparam logic [4:0] TkStr     = 5'd11;
    localparam logic [4:0] TkSymBase = 5'd12;

    // character codes
    localparam logic [7:0] ChNul   = 8'h00;
    localparam logic [7:0] ChNl    = 8'h0A;
    localparam logic [7:0] ChQuote = 8'h27;
    localparam logic [7:0] ChUnder = 8'h5F;

    localparam logic [15:0] LineMax = 16'hFFFF;

    // one output record without its line
    typedef struct packed {
        logic [1:0] rk;
        logic [4:0] tk;
        logic [7:0] vb;
        logic [5:0] len;
    } t_rec;

    // all records caused by one input byte
    typedef struct packed {
        logic [1:0]      cnt;
        logic [15:0]     line;
        t_rec [2:0]      recs;
    } t_bundle;

    // keyword text, character i in bits [8*i+7:8*i]
    function automatic logic [63:0] kw_word(input logic [2:0] k);
        logic [63:0] w;
        case (k)
            3'd0:    w = {16'h0, "TCELES"};
            3'd1:    w = {16'h0, "TRESNI"};
            3'd2:    w = {32'h0, "OTNI"};
            3'd3:    w = {32'h0, "MORF"};
            3'd4:    w = {24'h0, "EREHW"};
            3'd5:    w = {16'h0, "SEULAV"};
            3'd6:    w = {8'h0, "NEEWTEB"};
            default: w = {40'h0, "DNA"};
        endcase
        return w;
    endfunction

    function automatic logic [2:0] kw_len(input logic [2:0] k);
        logic [2:0] l;
        case (k)
            3'd0:    l = 3'd6;
            3'd1:    l = 3'd6;
            3'd2:    l = 3'd4;
            3'd3:    l = 3'd4;
            3'd4:    l = 3'd5;
            3'd5:    l = 3'd6;
            3'd6:    l = 3'd7;
            default: l = 3'd3;
        endcase
        return l;
    endfunction

    // drop keywords that are too short for pos or whose character at pos differs from the upper-case byte
    function automatic logic [7:0] kw_match(input logic [7:0] mask, input logic [5:0] pos,
                                            input logic [7:0] up);
        logic [7:0]  m;
        logic [63:0] w;
        m = mask;
        for (int k = 0; k < 8; k++) begin
            w = kw_word(3'(k));
            if (pos >= {3'b000, kw_len(3'(k))} || w[8*pos[2:0] +: 8] != up) begin
                m[k] = 1'b0;
            end
        end
        return m;
    endfunction

    // first keyword still matching at full length, else identifier
    function automatic logic [4:0] word_kind(input logic [7:0] mask, input logic [5:0] cnt);
        logic [4:0] kind;
        kind = TkIdent;
        for (int k = 7; k >= 0; k--) begin
            if (mask[k] && cnt == {3'b000, kw_len(3'(k))}) begin
                kind = 5'(k + 1);
            end
        end
        return kind;
    endfunction

    // symbol lookup: bit 3 hit, bits 2:0 symbol index
    function automatic logic [3:0] sym_index(input logic [7:0] b);
        logic [3:0] r;
        case (b)
            8'h2A:   r = 4'b1000;
            8'h2C:   r = 4'b1001;
            8'h28:   r = 4'b1010;
            8'h29:   r = 4'b1011;
            8'h3D:   r = 4'b1100;
            8'h3B:   r = 4'b1101;
            default: r = 4'b0000;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/sts_front.sv -----
// front end: takes text bytes, runs the lexer state and builds record bundles
`timescale 1ns / 1ps

module sts_front #(
    parameter int VALUE_MAX = sts_pkg::ValueMaxDefault
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_byte,
    input  logic             i_full,
    output logic             o_push,
    output sts_pkg::t_bundle o_bundle
);
    import sts_pkg::*;

    localparam int StoreLim = (VALUE_MAX < 63) ? VALUE_MAX : 63;
    localparam logic [5:0] StoreLimC = 6'(StoreLim);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_NUM,
        MODE_STR,
        MODE_SKIP
    } t_mode;

    t_mode       r_mode, n_mode;
    logic [15:0] r_line, n_line;
    logic [5:0]  r_count, n_count;
    logic [7:0]  r_mask, n_mask;

    logic        w_accept;
    logic [7:0]  w_up;
    logic        w_alpha, w_digit, w_word, w_space;
    logic [3:0]  w_sym;
    t_rec [2:0]  w_recs;
    logic [1:0]  w_cnt;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && o_ready;

    // byte classes
    assign w_alpha = (i_byte >= "A" && i_byte <= "Z") || (i_byte >= "a" && i_byte <= "z");
    assign w_digit = i_byte >= "0" && i_byte <= "9";
    assign w_word  = w_alpha || w_digit || i_byte == ChUnder;
    assign w_space = i_byte == " " || (i_byte >= 8'd9 && i_byte <= 8'd13);
    assign w_up    = (i_byte >= "a" && i_byte <= "z") ? i_byte - 8'd32 : i_byte;
    assign w_sym   = sym_index(i_byte);

    // next state and records for this byte
    always_comb begin
        logic       do_idle;
        logic [1:0] idx;
        do_idle = 1'b0;
        idx     = 2'd0;
        w_recs  = '0;
        n_mode  = r_mode;
        n_line  = r_line;
        n_count = r_count;
        n_mask  = r_mask;

        case (r_mode)
            MODE_SKIP: begin
                if (i_byte == ChNul) begin
                    n_mode  = MODE_IDLE;
                    n_line  = 16'd1;
                    n_count = '0;
                    n_mask  = '0;
                end
            end
            MODE_STR: begin
                if (i_byte == ChNul) begin
                    w_recs[idx] = '{RkOpenStr, TkEof, 8'h00, 6'd0};
                    idx = idx + 2'd1;
                    n_mode  = MODE_IDLE;
                    n_line  = 16'd1;
                    n_count = '0;
                    n_mask  = '0;
                end else if (i_byte == ChQuote) begin
                    w_recs[idx] = '{RkToken, TkStr, 8'h00, r_count};
                    idx = idx + 2'd1;
                    n_mode = MODE_IDLE;
                end else if (r_count < StoreLimC) begin
                    w_recs[idx] = '{RkValue, TkEof, i_byte, 6'd0};
                    idx = idx + 2'd1;
                    n_count = r_count + 6'd1;
                end
            end
            MODE_WORD: begin
                if (w_word) begin
                    n_mask = kw_match(r_mask, r_count, w_up);
                    if (r_count < StoreLimC) begin
                        w_recs[idx] = '{RkValue, TkEof, i_byte, 6'd0};
                        idx = idx + 2'd1;
                        n_count = r_count + 6'd1;
                    end
                end else begin
                    w_recs[idx] = '{RkToken, word_kind(r_mask, r_count), 8'h00, r_count};
                    idx = idx + 2'd1;
                    do_idle = 1'b1;
                end
            end
            MODE_NUM: begin
                if (w_digit) begin
                    if (r_count < StoreLimC) begin
                        w_recs[idx] = '{RkValue, TkEof, i_byte, 6'd0};
                        idx = idx + 2'd1;
                        n_count = r_count + 6'd1;
                    end
                end else begin
                    w_recs[idx] = '{RkToken, TkInt, 8'h00, r_count};
                    idx = idx + 2'd1;
                    do_idle = 1'b1;
                end
            end
            default: begin
                do_idle = 1'b1;
            end
        endcase

        // handling between tokens, also after a delimiting byte
        if (do_idle) begin
            n_mode  = MODE_IDLE;
            n_count = '0;
            n_mask  = '0;
            if (i_byte == ChNul) begin
                w_recs[idx] = '{RkToken, TkEof, 8'h00, 6'd0};
                idx = idx + 2'd1;
                n_line = 16'd1;
            end else if (w_space) begin
                if (i_byte == ChNl && r_line != LineMax) begin
                    n_line = r_line + 16'd1;
                end
            end else if (w_alpha || i_byte == ChUnder) begin
                n_mode  = MODE_WORD;
                n_mask  = kw_match(8'hFF, 6'd0, w_up);
                n_count = 6'd1;
                w_recs[idx] = '{RkValue, TkEof, i_byte, 6'd0};
                idx = idx + 2'd1;
            end else if (w_digit) begin
                n_mode  = MODE_NUM;
                n_count = 6'd1;
                w_recs[idx] = '{RkValue, TkEof, i_byte, 6'd0};
                idx = idx + 2'd1;
            end else if (i_byte == ChQuote) begin
                n_mode = MODE_STR;
            end else if (w_sym[3]) begin
                w_recs[idx] = '{RkValue, TkEof, i_byte, 6'd0};
                idx = idx + 2'd1;
                w_recs[idx] = '{RkToken, TkSymBase + {2'b00, w_sym[2:0]}, 8'h00, 6'd1};
                idx = idx + 2'd1;
            end else begin
                w_recs[idx] = '{RkBadChar, TkEof, i_byte, 6'd0};
                idx = idx + 2'd1;
                n_mode = MODE_SKIP;
            end
        end
        w_cnt = idx;
    end

    // bundle to the queue, all records share the line of this byte
    assign o_push        = w_accept && w_cnt != 2'd0;
    assign o_bundle.cnt  = w_cnt;
    assign o_bundle.line = r_line;
    assign o_bundle.recs = w_recs;

    // lexer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_line  <= 16'd1;
            r_count <= '0;
            r_mask  <= '0;
        end else if (w_accept) begin
            r_mode  <= n_mode;
            r_line  <= n_line;
            r_count <= n_count;
            r_mask  <= n_mask;
        end
    end

endmodule

// ----- rtl/core/sts_queue.sv -----
// short queue of record bundles between front and back end
`timescale 1ns / 1ps

module sts_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  sts_pkg::t_bundle i_bundle,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output sts_pkg::t_bundle o_head
);
    import sts_pkg::*;

    t_bundle              r_mem [QueueDepth];
    logic [QueuePtrW-1:0] r_wr, r_rd;
    logic [QueuePtrW:0]   r_level;

    assign o_full  = r_level == (QueuePtrW + 1)'(QueueDepth);
    assign o_empty = r_level == '0;
    assign o_head  = r_mem[r_rd];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_bundle;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QueuePtrW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QueuePtrW'(1);
            end
            if (i_push && !i_pop) begin
                r_level <= r_level + (QueuePtrW + 1)'(1);
            end else if (!i_push && i_pop) begin
                r_level <= r_level - (QueuePtrW + 1)'(1);
            end
        end
    end

endmodule

// ----- rtl/core/sts_back.sv -----
// back end: unpacks one bundle at a time into single output records
`timescale 1ns / 1ps

module sts_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  sts_pkg::t_bundle i_head,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output sts_pkg::t_rec    o_rec,
    output logic [15:0]      o_line,
    output logic             o_last
);
    import sts_pkg::*;

    t_bundle    r_bun;
    logic [1:0] r_idx;
    logic       r_have;
    logic       w_xfer;

    assign o_valid = r_have;
    assign o_rec   = r_bun.recs[r_idx];
    assign o_line  = r_bun.line;
    assign o_last  = r_idx == 2'(r_bun.cnt - 2'd1);
    assign w_xfer  = r_have && i_ready;

    // take the next bundle when none is held or the held one finishes
    assign o_pop = !i_empty && (!r_have || (w_xfer && o_last));

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bun <= i_head;
        end
    end

    // record index and hold flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_idx  <= '0;
        end else if (o_pop) begin
            r_have <= 1'b1;
            r_idx  <= '0;
        end else if (w_xfer) begin
            if (o_last) begin
                r_have <= 1'b0;
                r_idx  <= '0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

endmodule

// ----- rtl/core/sql_token_scanner_top.sv -----
// Byte-serial SQL lexer. One text byte is taken per clock while the record queue has room;
// each byte yields zero to three records (value-byte echo, token complete, error), which
// the back end sends one per cycle while the output is ready, the record kind on tuser
// and the last record of a byte flagged by tlast. The sustained input rate is one byte
// per cycle as long as bytes average at most one record each and the output is ready;
// the output serializer, one record per cycle, sets the limit otherwise, and a four-bundle
// queue absorbs bursts such as a symbol after an identifier. A record passes through the
// queue and the back-end bundle register before it reaches the output. A zero byte ends
// the statement and resets the line counter; after an error the rest of the statement is
// dropped without records.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sql_token_scanner_top #(
    parameter int VALUE_MAX = sts_pkg::ValueMaxDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [4:0] token_kind, [12:5] value_byte,
                                        // [18:13] value_length, [34:19] line_number,
                                        // [39:35] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] record_kind
    output logic        m_axis_tlast    // last_of_run
);
    import sts_pkg::*;

    logic        w_push, w_full, w_pop, w_empty;
    t_bundle     w_in_bundle, w_head;
    t_rec        w_rec;
    logic [15:0] w_line;

    sts_front #(
        .VALUE_MAX (VALUE_MAX)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_byte   (s_axis_tdata),
        .i_full   (w_full),
        .o_push   (w_push),
        .o_bundle (w_in_bundle)
    );

    sts_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_bundle (w_in_bundle),
        .o_full   (w_full),
        .i_pop    (w_pop),
        .o_empty  (w_empty),
        .o_head   (w_head)
    );

    sts_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_rec   (w_rec),
        .o_line  (w_line),
        .o_last  (m_axis_tlast)
    );

    // output record packing
    assign m_axis_tdata = {5'b00000, w_line, w_rec.len, w_rec.vb, w_rec.tk};
    assign m_axis_tuser = w_rec.rk;

    // no write into a full queue, no read from an empty one
    `STS_ASSERT(a_push_not_full, i_clk, i_rst_n, w_push |-> !w_full, "push into full queue")
    `STS_ASSERT(a_pop_not_empty, i_clk, i_rst_n, w_pop |-> !w_empty, "pop from empty queue")
    // an idle back end picks up a waiting bundle in the next cycle
    `STS_ASSERT(a_back_picks_up, i_clk, i_rst_n, (!m_axis_tvalid && !w_empty) |=> m_axis_tvalid, "bundle not taken")

endmodule
